>>> hw/rtl/gfmix_pkg.sv
// Shared types, constants and GF(2^8) helpers for the column mix unit.
// No dependencies; compile this file first.
`default_nettype none

package gfmix_pkg;

	localparam int BYTE_W = 8;
	localparam int ROW_N  = 4;
	localparam int WORD_W = BYTE_W * ROW_N;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;

	// Low byte of the AES field polynomial x^8 + x^4 + x^3 + x + 1
	localparam byte_t REDUCE_POLY = 8'h1B;

	// Forward MixColumns matrix, byte j of a row multiplies column byte j
	localparam word_t ROW0_RST = 32'h0101_0302;
	localparam word_t ROW1_RST = 32'h0103_0201;
	localparam word_t ROW2_RST = 32'h0302_0101;
	localparam word_t ROW3_RST = 32'h0201_0103;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} cfg_idx_t;

	// Multiply by x with reduction
	function automatic byte_t xtime(input byte_t a);
		xtime = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? REDUCE_POLY : '0);
	endfunction

	// Field product: shift-and-add over the bits of b
	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t x;
		acc = '0;
		x   = a;
		for (int i = 0; i < BYTE_W; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = xtime(x);
		end
		gf_mul = acc;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gfmix_in_if.sv
// Input channel carrying one state column per transfer.
// Depends on gfmix_pkg.
`default_nettype none

interface gfmix_in_if
	import gfmix_pkg::*;
;
	logic  valid;
	logic  ready;
	word_t column_in;

	modport source (output valid, output column_in, input ready);
	modport sink   (input valid, input column_in, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gfmix_out_if.sv
// Output channel carrying one mixed column per transfer.
// Depends on gfmix_pkg.
`default_nettype none

interface gfmix_out_if
	import gfmix_pkg::*;
;
	logic  valid;
	logic  ready;
	word_t column_out;

	modport source (output valid, output column_out, input ready);
	modport sink   (input valid, input column_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gf256_matrix_column_mix_unit.sv
// Column mix unit: multiplies a state column by a 4x4 matrix over GF(2^8).
// Usage:
//   col_in   valid/ready channel, one 32-bit column per transfer, byte j at bits 8j+7..8j.
//   col_out  valid/ready channel, one mixed column per accepted input, in order.
//   cfg_*    write port for the four matrix rows; write only while the unit is idle.
// A column taken from col_in passes the input register, then the result register, to col_out.
// Throughput: one column per cycle unless col_out stalls; the input register feeds four
// row dot products (byte products by shift-and-reduce) straight into the output register.
// Reset loads the forward MixColumns matrix and empties both registers.
// Load the 0E 0B 0D 09 circulant to get the inverse transform.
// When col_out stalls, the output register holds its column and the input
// register still takes one more column; col_in.ready drops only when both are full.
// Depends on gfmix_pkg, gfmix_in_if, gfmix_out_if, gfmix_cfg_regs, gfmix_row_dot.
`default_nettype none

module gf256_matrix_column_mix_unit
	import gfmix_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	gfmix_in_if.sink      col_in,
	gfmix_out_if.source   col_out,
	input  wire logic     cfg_we,
	input  wire cfg_idx_t cfg_index,
	input  wire word_t    cfg_wdata
);

	word_t matrix [ROW_N];
	logic  valid_s1, valid_s2;
	word_t column_s1, column_s2;
	word_t mixed;
	logic  ready_s1, ready_s2;

	gfmix_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.matrix    (matrix)
	);

	// One dot product per output byte
	for (genvar r = 0; r < ROW_N; r++) begin : g_row
		gfmix_row_dot u_dot (
			.row    (matrix[r]),
			.column (column_s1),
			.dot    (mixed[r*BYTE_W +: BYTE_W])
		);
	end

	// A stage advances when it is empty or its contents move on
	assign ready_s2     = !valid_s2 || col_out.ready;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign col_in.ready = ready_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= col_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && col_in.valid) begin
			column_s1 <= col_in.column_in;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			column_s2 <= mixed;
		end
	end

	assign col_out.valid      = valid_s2;
	assign col_out.column_out = column_s2;

endmodule

`default_nettype wire

>>> hw/rtl/gfmix_cfg_regs.sv
// Matrix row registers with their plain write port.
// Depends on gfmix_pkg.
`default_nettype none

module gfmix_cfg_regs
	import gfmix_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire cfg_idx_t cfg_index,
	input  wire word_t    cfg_wdata,
	output word_t         matrix [ROW_N]
);

	word_t row0_q, row1_q, row2_q, row3_q;

	// Load the addressed row; reset to the forward matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= ROW0_RST;
			row1_q <= ROW1_RST;
			row2_q <= ROW2_RST;
			row3_q <= ROW3_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0: row0_q <= cfg_wdata;
				REG_ROW1: row1_q <= cfg_wdata;
				REG_ROW2: row2_q <= cfg_wdata;
				REG_ROW3: row3_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign matrix[0] = row0_q;
	assign matrix[1] = row1_q;
	assign matrix[2] = row2_q;
	assign matrix[3] = row3_q;

endmodule

`default_nettype wire

>>> hw/rtl/gfmix_row_dot.sv
// GF(2^8) dot product of one matrix row with one column.
// Depends on gfmix_pkg.
`default_nettype none

module gfmix_row_dot
	import gfmix_pkg::*;
(
	input  wire word_t row,
	input  wire word_t column,
	output byte_t      dot
);

	// XOR the four byte products together
	always_comb begin
		dot = '0;
		for (int j = 0; j < ROW_N; j++) begin
			dot = dot ^ gf_mul(row[j*BYTE_W +: BYTE_W], column[j*BYTE_W +: BYTE_W]);
		end
	end

endmodule

`default_nettype wire
